@@ src/assert_macros.svh @@
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising clock edge outside reset
`define FIDEC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every rising clock edge, reset included
`define FIDEC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/fidec_pkg.sv @@
package fidec_pkg;

   // frame framing bytes and length
   localparam logic [7:0] FRAME_START   = 8'h02;
   localparam logic [7:0] FRAME_END     = 8'h03;
   localparam logic [3:0] FRAME_LAST    = 4'd11;
   localparam logic [3:0] INDEX_MAX     = 4'd15;

   // byte positions kept from the frame
   localparam logic [3:0] POS_START     = 4'd0;
   localparam logic [3:0] POS_DIRECTION = 4'd1;
   localparam logic [3:0] POS_TENS      = 4'd3;
   localparam logic [3:0] POS_ONES      = 4'd4;
   localparam logic [3:0] POS_MODE      = 4'd5;

   // ascii codes used by the decoder
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_1     = 8'h31;
   localparam logic [7:0] CHAR_2     = 8'h32;
   localparam logic [7:0] CHAR_3     = 8'h33;
   localparam logic [7:0] CHAR_4     = 8'h34;
   localparam logic [7:0] CHAR_8     = 8'h38;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_Z     = 8'h5A;
   localparam logic [7:0] CHAR_B     = 8'h42;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      DIR_STOP    = 2'd0,
      DIR_UP      = 2'd1,
      DIR_DOWN    = 2'd2,
      DIR_UNKNOWN = 2'd3
   } direction_type;

   typedef enum logic [2:0] {
      MODE_NORMAL   = 3'd0,
      MODE_FULL     = 3'd1,
      MODE_OVERLOAD = 3'd2,
      MODE_FIRE     = 3'd3,
      MODE_REPAIR   = 3'd4,
      MODE_UNKNOWN  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_DIGITS = 2'd1,
      KIND_PREFIX = 2'd2,
      KIND_LETTER = 2'd3
   } kind_type;

   // one received byte
   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_frame;
   } req_type;

   // one decoded frame
   typedef struct packed {
      logic              displayable;
      logic              format_ok;
      logic [1:0]        direction;
      logic [2:0]        work_mode;
      logic [7:0]        direction_raw;
      logic [7:0]        mode_raw;
      logic              floor_valid;
      logic signed [7:0] floor_number;
      logic [1:0]        floor_kind;
      logic [7:0]        tens_or_prefix;
      logic [3:0]        ones_digit;
      logic [7:0]        floor_letter;
   } rsp_type;

   // frame record handed from the front end to the decoder
   typedef struct packed {
      logic       format_ok;
      logic [7:0] direction_byte;
      logic [7:0] tens_byte;
      logic [7:0] ones_byte;
      logic [7:0] mode_byte;
   } frame_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_0) && (c <= CHAR_9);
   endfunction

   function automatic logic is_upper(input logic [7:0] c);
      return (c >= CHAR_A) && (c <= CHAR_Z);
   endfunction

endpackage

@@ src/fidec_front.sv @@
module fidec_front
   import fidec_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_push,
   input  req_type   req_data,
   input  logic      queue_full,
   output logic      req_full,
   output logic      frame_push,
   output frame_type frame_data
);

   logic [3:0] byte_index_ff, byte_index_in;
   logic       start_ok_ff, start_ok_in;
   logic [7:0] direction_byte_ff, direction_byte_in;
   logic [7:0] tens_byte_ff, tens_byte_in;
   logic [7:0] ones_byte_ff, ones_byte_in;
   logic [7:0] mode_byte_ff, mode_byte_in;
   logic       accept;

   // a byte is taken only when the frame queue has room
   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   // byte position and captured fields
   always_comb begin
      byte_index_in     = byte_index_ff;
      start_ok_in       = start_ok_ff;
      direction_byte_in = direction_byte_ff;
      tens_byte_in      = tens_byte_ff;
      ones_byte_in      = ones_byte_ff;
      mode_byte_in      = mode_byte_ff;
      if (accept) begin
         case (byte_index_ff)
            POS_START:     start_ok_in       = (req_data.byte_value == FRAME_START);
            POS_DIRECTION: direction_byte_in = req_data.byte_value;
            POS_TENS:      tens_byte_in      = req_data.byte_value;
            POS_ONES:      ones_byte_in      = req_data.byte_value;
            POS_MODE:      mode_byte_in      = req_data.byte_value;
            default:       ;
         endcase
         if (req_data.end_of_frame) begin
            byte_index_in = '0;
            start_ok_in   = 1'b0;
         end else if (byte_index_ff != INDEX_MAX) begin
            byte_index_in = byte_index_ff + 4'd1;
         end
      end
   end

   // frame record on the last byte
   always_comb begin
      frame_push                = accept && req_data.end_of_frame;
      frame_data.format_ok      = (byte_index_ff == FRAME_LAST) && start_ok_ff
                                  && (req_data.byte_value == FRAME_END);
      frame_data.direction_byte = direction_byte_ff;
      frame_data.tens_byte      = tens_byte_ff;
      frame_data.ones_byte      = ones_byte_ff;
      frame_data.mode_byte      = mode_byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         start_ok_ff   <= 1'b0;
      end else begin
         byte_index_ff <= byte_index_in;
         start_ok_ff   <= start_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      direction_byte_ff <= direction_byte_in;
      tens_byte_ff      <= tens_byte_in;
      ones_byte_ff      <= ones_byte_in;
      mode_byte_ff      <= mode_byte_in;
   end

endmodule

@@ src/fidec_queue.sv @@
module fidec_queue
   import fidec_pkg::*;
#(
   parameter int DEPTH = 2
)(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_data,
   output logic      full,
   input  logic      pop,
   output frame_type pop_data,
   output logic      empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ src/fidec_back.sv @@
module fidec_back
   import fidec_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      frame_empty,
   input  frame_type frame_data,
   output logic      frame_pop,
   output logic      rsp_empty,
   input  logic      rsp_pop,
   output rsp_type   rsp_data
);

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    load;

   // take the next frame when the result register is free or being drained
   assign load      = !frame_empty && (!rsp_valid_ff || rsp_pop);
   assign frame_pop = load;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // decode direction, mode and floor text
   always_comb begin
      logic [7:0]        t;
      logic [7:0]        o;
      logic [3:0]        t_val;
      logic [3:0]        o_val;
      logic              o_dig;
      logic              t_dig;
      logic              t_prefix;
      logic              valid;
      logic signed [7:0] num;

      t        = frame_data.tens_byte;
      o        = frame_data.ones_byte;
      t_val    = 4'(t - CHAR_0);
      o_val    = 4'(o - CHAR_0);
      o_dig    = is_digit(o);
      t_dig    = is_digit(t);
      t_prefix = (t == CHAR_B) || (t == CHAR_DASH);

      rsp_in = '0;

      // numeric floor value
      valid = 1'b0;
      num   = '0;
      if (((t == CHAR_SLASH) || (t == CHAR_SPACE)) && o_dig) begin
         valid = 1'b1;
         num   = 8'({4'b0, o_val});
      end else if (t_dig && o_dig) begin
         valid = 1'b1;
         num   = 8'(t_val * 8'd10) + 8'({4'b0, o_val});
      end else if (t_prefix && o_dig) begin
         valid = 1'b1;
         num   = 8'd0 - 8'({4'b0, o_val});
      end

      if (frame_data.format_ok) begin
         rsp_in.format_ok     = 1'b1;
         rsp_in.direction_raw = frame_data.direction_byte;
         rsp_in.mode_raw      = frame_data.mode_byte;

         case (frame_data.direction_byte)
            CHAR_0:  rsp_in.direction = DIR_STOP;
            CHAR_1:  rsp_in.direction = DIR_UP;
            CHAR_3:  rsp_in.direction = DIR_DOWN;
            default: rsp_in.direction = DIR_UNKNOWN;
         endcase

         case (frame_data.mode_byte)
            CHAR_8:  rsp_in.work_mode = MODE_NORMAL;
            CHAR_1:  rsp_in.work_mode = MODE_FULL;
            CHAR_2:  rsp_in.work_mode = MODE_OVERLOAD;
            CHAR_3:  rsp_in.work_mode = MODE_FIRE;
            CHAR_4:  rsp_in.work_mode = MODE_REPAIR;
            default: rsp_in.work_mode = MODE_UNKNOWN;
         endcase

         // floor display classification, first matching rule wins
         if (is_upper(t) && (o == CHAR_SPACE)) begin
            rsp_in.floor_kind   = KIND_LETTER;
            rsp_in.floor_letter = t;
         end else if ((t == CHAR_SPACE) && is_upper(o)) begin
            rsp_in.floor_kind   = KIND_LETTER;
            rsp_in.floor_letter = o;
         end else if (t_prefix && o_dig) begin
            rsp_in.floor_kind     = KIND_PREFIX;
            rsp_in.tens_or_prefix = t;
            rsp_in.ones_digit     = o_val;
         end else if (o_dig) begin
            rsp_in.floor_kind     = KIND_DIGITS;
            rsp_in.tens_or_prefix = t_dig ? 8'({4'b0, t_val}) : 8'd0;
            rsp_in.ones_digit     = o_val;
         end

         rsp_in.floor_valid  = valid;
         rsp_in.floor_number = valid ? num : 8'sd0;
         rsp_in.displayable  = valid || (rsp_in.floor_kind == KIND_LETTER);
      end else begin
         rsp_in.direction = DIR_UNKNOWN;
         rsp_in.work_mode = MODE_UNKNOWN;
      end
   end

   // result register occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ src/floor_indicator_frame_decoder_unit.sv @@
// Elevator floor indicator frame decoder. Frame bytes enter one per request through a
// push/full queue port, with end_of_frame set on the last byte of each frame; one byte can
// be taken every clock cycle while the frame queue has room. Each frame yields one decoded
// result on the empty/pop side: the front end captures the frame into a small frame queue
// (QUEUE_DEPTH records), and the decoder moves the oldest record through a single result
// register. Bytes are refused only while that frame queue is full, so a byte stream keeps
// its one byte per cycle as long as results are drained. A frame is well formed when it is
// 12 bytes long, starts with 0x02 and ends with 0x03; otherwise the result carries
// direction unknown, mode unknown and zero in every other field.
module floor_indicator_frame_decoder_unit
   import fidec_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic      frame_push;
   frame_type frame_in;
   logic      queue_full;
   logic      frame_pop;
   frame_type frame_out;
   logic      frame_empty;

   // byte capture and framing check
   fidec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (queue_full),
      .req_full   (req_full),
      .frame_push (frame_push),
      .frame_data (frame_in)
   );

   // frame records waiting for the decoder
   fidec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_push),
      .push_data (frame_in),
      .full      (queue_full),
      .pop       (frame_pop),
      .pop_data  (frame_out),
      .empty     (frame_empty)
   );

   // field decode and result register
   fidec_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_empty (frame_empty),
      .frame_data  (frame_out),
      .frame_pop   (frame_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

endmodule

@@ src/fidec_checker.sv @@
`include "assert_macros.svh"

module fidec_checker
   import fidec_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   logic present;
   logic waiting;
   logic bad_frame_clean;
   logic floor_framed;

   // result shown, and result shown but not taken
   assign present = !rsp_empty;
   assign waiting = present && !rsp_pop;

   // a malformed frame reports unknown codes and nothing else
   assign bad_frame_clean = rsp_data.format_ok
                            || ((rsp_data.direction == DIR_UNKNOWN)
                                && (rsp_data.work_mode == MODE_UNKNOWN)
                                && !rsp_data.floor_valid && !rsp_data.displayable
                                && (rsp_data.floor_kind == KIND_NONE));

   // a numeric floor only comes from a well formed frame and is always displayable
   assign floor_framed = !rsp_data.floor_valid
                         || (rsp_data.format_ok && rsp_data.displayable);

   // no result is pending right after reset
   `FIDEC_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> rsp_empty, "result after reset")

   // malformed frame shape
   `FIDEC_ASSERT(a_malformed_shape, clock, reset, present |-> bad_frame_clean, "bad frame fields")

   // numeric floor framing
   `FIDEC_ASSERT(a_valid_floor, clock, reset, present |-> floor_framed, "floor without framing")

   // a result waiting for pop does not change
   `FIDEC_ASSERT(a_result_held, clock, reset, waiting |=> present && $stable(rsp_data), "result moved")

endmodule

bind floor_indicator_frame_decoder_unit fidec_checker u_checker (.*);
